// ----- rtl/core/metaball_marching_squares_cell_core_macros.svh -----
// Assertion macros shared by the metaball cell core.
`ifndef METABALL_MARCHING_SQUARES_CELL_CORE_MACROS_SVH
`define METABALL_MARCHING_SQUARES_CELL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MMSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mmsc assertion failed");
`define MMSC_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mmsc reset assertion failed");
`else
`define MMSC_ASSERT(lbl, clk, rst, prop)
`define MMSC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/mmsc_pkg.sv -----
// Shared types, vertex codes and polygon table for the metaball cell core.
package mmsc_pkg;

   localparam int SUM_W     = 24;
   localparam int COORD_W   = 10;
   localparam int RSQ_W     = 20;
   localparam int DIV_STEPS = 24;
   localparam int ENT_FIX   = RSQ_W + 2 * COORD_W + 2;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [SUM_W-1:0] ISO_RESET = 24'h010000;

   // vertex codes: corners, edge midpoints, end of list
   localparam logic [3:0] VTX_TL  = 4'd0;
   localparam logic [3:0] VTX_TR  = 4'd1;
   localparam logic [3:0] VTX_BR  = 4'd2;
   localparam logic [3:0] VTX_BL  = 4'd3;
   localparam logic [3:0] VTX_TM  = 4'd4;
   localparam logic [3:0] VTX_LM  = 4'd5;
   localparam logic [3:0] VTX_RM  = 4'd6;
   localparam logic [3:0] VTX_BM  = 4'd7;
   localparam logic [3:0] VTX_END = 4'd8;

   localparam logic [3:0] POLY_TABLE [0:15][0:5] = '{
      '{VTX_END, VTX_END, VTX_END, VTX_END, VTX_END, VTX_END},
      '{VTX_LM,  VTX_TL,  VTX_TM,  VTX_END, VTX_END, VTX_END},
      '{VTX_TM,  VTX_TR,  VTX_RM,  VTX_END, VTX_END, VTX_END},
      '{VTX_LM,  VTX_TL,  VTX_TR,  VTX_RM,  VTX_END, VTX_END},
      '{VTX_RM,  VTX_BR,  VTX_BM,  VTX_END, VTX_END, VTX_END},
      '{VTX_LM,  VTX_TL,  VTX_TM,  VTX_RM,  VTX_BR,  VTX_BM},
      '{VTX_TM,  VTX_TR,  VTX_BR,  VTX_BM,  VTX_END, VTX_END},
      '{VTX_TL,  VTX_TR,  VTX_BR,  VTX_BM,  VTX_LM,  VTX_END},
      '{VTX_LM,  VTX_BL,  VTX_BM,  VTX_END, VTX_END, VTX_END},
      '{VTX_BM,  VTX_BL,  VTX_LM,  VTX_TL,  VTX_TM,  VTX_END},
      '{VTX_BM,  VTX_BL,  VTX_LM,  VTX_TM,  VTX_TR,  VTX_RM},
      '{VTX_BL,  VTX_TL,  VTX_TR,  VTX_RM,  VTX_BM,  VTX_END},
      '{VTX_LM,  VTX_RM,  VTX_BR,  VTX_BL,  VTX_END, VTX_END},
      '{VTX_TL,  VTX_TM,  VTX_RM,  VTX_BR,  VTX_BL,  VTX_END},
      '{VTX_BL,  VTX_BR,  VTX_TR,  VTX_TM,  VTX_LM,  VTX_END},
      '{VTX_TL,  VTX_TR,  VTX_BR,  VTX_BL,  VTX_END, VTX_END}
   };

   typedef struct packed {
      logic [3:0]         case_index;
      logic               vertex_valid;
      logic [COORD_W-1:0] vertex_x;
      logic [COORD_W-1:0] vertex_y;
      logic               last_vertex;
   } rsp_word_type;

endpackage

// ----- rtl/core/mmsc_front.sv -----
// Front end: register the word, form corner distances and squares, push to the queue.
module mmsc_front #(
   parameter int CELL_SIZE = 5,
   parameter int CRD_W     = 11,
   parameter int DW        = 14,
   parameter int D2W       = 28,
   parameter int EW        = 154
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [7:0]           cell_col,
   input  logic [6:0]           cell_row,
   input  logic signed [11:0]   ball_x,
   input  logic signed [11:0]   ball_y,
   input  logic [9:0]           ball_radius,
   input  logic                 first_ball,
   input  logic                 last_ball,
   output logic                 push_valid,
   output logic [EW-1:0]        push_data,
   input  logic                 push_full
);

   logic                  s1_valid_ff, s2_valid_ff;
   logic [7:0]            col_ff;
   logic [6:0]            row_ff;
   logic signed [11:0]    bx_ff, by_ff;
   logic [9:0]            rad_ff;
   logic                  first_ff, last_ff;

   logic [2*DW-1:0]       sxa_ff, sxb_ff, sya_ff, syb_ff;
   logic [mmsc_pkg::RSQ_W-1:0]   rsq_ff;
   logic [mmsc_pkg::COORD_W-1:0] x0o_ff, y0o_ff;
   logic                  s2_first_ff, s2_last_ff;

   logic [CRD_W-1:0]      x0, y0, x1, y1;
   logic signed [DW-1:0]  dxa, dxb, dya, dyb, bxe, bye;
   logic                  s2_move, s2_take;
   logic [D2W-1:0]        d2_tl, d2_tr, d2_br, d2_bl;

   assign s2_move  = s2_valid_ff && !push_full;
   assign s2_take  = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign in_stall = s1_valid_ff && !(!s2_valid_ff || s2_move);

   always_comb begin
      x0  = CRD_W'(32'(col_ff) * CELL_SIZE);
      y0  = CRD_W'(32'(row_ff) * CELL_SIZE);
      x1  = x0 + CRD_W'(CELL_SIZE);
      y1  = y0 + CRD_W'(CELL_SIZE);
      bxe = DW'(bx_ff);
      bye = DW'(by_ff);
      dxa = bxe - $signed({{(DW-CRD_W){1'b0}}, x0});
      dxb = bxe - $signed({{(DW-CRD_W){1'b0}}, x1});
      dya = bye - $signed({{(DW-CRD_W){1'b0}}, y0});
      dyb = bye - $signed({{(DW-CRD_W){1'b0}}, y1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_take || (s2_valid_ff && !s2_move);
         s1_valid_ff <= (in_valid && !in_stall) || (s1_valid_ff && !s2_take);
      end
      if (in_valid && !in_stall) begin
         col_ff   <= cell_col;
         row_ff   <= cell_row;
         bx_ff    <= ball_x;
         by_ff    <= ball_y;
         rad_ff   <= ball_radius;
         first_ff <= first_ball;
         last_ff  <= last_ball;
      end
      if (s2_take) begin
         sxa_ff      <= (2*DW)'(dxa * dxa);
         sxb_ff      <= (2*DW)'(dxb * dxb);
         sya_ff      <= (2*DW)'(dya * dya);
         syb_ff      <= (2*DW)'(dyb * dyb);
         rsq_ff      <= rad_ff * rad_ff;
         x0o_ff      <= x0[mmsc_pkg::COORD_W-1:0];
         y0o_ff      <= y0[mmsc_pkg::COORD_W-1:0];
         s2_first_ff <= first_ff;
         s2_last_ff  <= last_ff;
      end
   end

   assign d2_tl = sxa_ff + sya_ff;
   assign d2_tr = sxb_ff + sya_ff;
   assign d2_br = sxb_ff + syb_ff;
   assign d2_bl = sxa_ff + syb_ff;

   assign push_valid = s2_valid_ff;
   assign push_data  = {d2_bl, d2_br, d2_tr, d2_tl, rsq_ff, x0o_ff, y0o_ff,
                        s2_first_ff, s2_last_ff};

endmodule

// ----- rtl/core/mmsc_queue.sv -----
// Two-entry queue between the front end and the back end.
module mmsc_queue #(
   parameter int EW = 154
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  logic [EW-1:0] push_data,
   output logic          full,
   output logic          pop_valid,
   output logic [EW-1:0] pop_data,
   input  logic          pop
);

   logic [EW-1:0] mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/core/mmsc_back.sv -----
// Back end: per-corner dividers, sum accumulation, classification and vertex output.
`include "metaball_marching_squares_cell_core_macros.svh"
module mmsc_back #(
   parameter int CELL_SIZE = 5,
   parameter int D2W       = 28,
   parameter int EW        = 154
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  logic [EW-1:0]              q_data,
   output logic                       q_pop,
   input  logic [mmsc_pkg::SUM_W-1:0] iso_threshold,
   output logic                       out_valid,
   output mmsc_pkg::rsp_word_type     out_word,
   input  logic                       out_stall
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_ACC, ST_EMIT} state_type;

   localparam int SW = mmsc_pkg::SUM_W;
   localparam int CW = mmsc_pkg::COORD_W;
   localparam logic [CW-1:0] CS_C   = CW'(CELL_SIZE);
   localparam logic [CW-1:0] HALF_C = CW'(CELL_SIZE / 2);

   state_type              state_ff;
   logic [D2W-1:0]         d2_ff  [4];
   logic [D2W-1:0]         rem_ff [4];
   logic [SW-1:0]          quo_ff [4];
   logic                   sat_ff [4];
   logic [SW-1:0]          sum_ff [4];
   logic [SW-1:0]          num_ff;
   logic [4:0]             step_ff;
   logic                   first_ff, last_ff;
   logic [CW-1:0]          x0_ff, y0_ff;
   logic [3:0]             case_ff;
   logic [2:0]             emit_idx_ff;
   logic                   rsp_valid_ff;
   mmsc_pkg::rsp_word_type rsp_ff;

   logic [D2W-1:0]         rem_in [4];
   logic [SW-1:0]          quo_in [4];
   logic [SW-1:0]          sum_in [4];
   logic [3:0]             case_in;
   logic [mmsc_pkg::RSQ_W-1:0] q_rsq;
   mmsc_pkg::rsp_word_type word_in;
   logic [3:0]             code, code_next;
   logic [CW-1:0]          off_x, off_y;
   logic                   emit_go;
   logic                   empty_ok;

   assign q_rsq   = q_data[mmsc_pkg::ENT_FIX-1 -: mmsc_pkg::RSQ_W];
   assign q_pop   = (state_ff == ST_IDLE) && q_valid;
   // load the output register when it is empty or being taken
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || !out_stall);

   // one quotient bit per lane per cycle, and the saturating accumulate
   always_comb begin
      logic [D2W:0]   shifted;
      logic           ge;
      logic [SW:0]    acc;
      logic [SW-1:0]  contrib;
      for (int i = 0; i < 4; i++) begin
         shifted   = {rem_ff[i], num_ff[SW-1]};
         ge        = shifted >= {1'b0, d2_ff[i]};
         rem_in[i] = ge ? D2W'(shifted - {1'b0, d2_ff[i]}) : D2W'(shifted);
         quo_in[i] = {quo_ff[i][SW-2:0], ge};
         contrib   = sat_ff[i] ? mmsc_pkg::SUM_MAX : quo_ff[i];
         acc       = {1'b0, first_ff ? {SW{1'b0}} : sum_ff[i]} + {1'b0, contrib};
         sum_in[i] = acc[SW] ? mmsc_pkg::SUM_MAX : acc[SW-1:0];
         case_in[i] = sum_in[i] >= iso_threshold;
      end
   end

   // vertex select for the current output slot
   always_comb begin
      code      = mmsc_pkg::POLY_TABLE[case_ff][emit_idx_ff];
      code_next = (emit_idx_ff == 3'd5) ? mmsc_pkg::VTX_END
                : mmsc_pkg::POLY_TABLE[case_ff][emit_idx_ff + 3'd1];
      unique case (code)
         mmsc_pkg::VTX_TR, mmsc_pkg::VTX_BR, mmsc_pkg::VTX_RM: off_x = CS_C;
         mmsc_pkg::VTX_TM, mmsc_pkg::VTX_BM:                   off_x = HALF_C;
         default:                                              off_x = '0;
      endcase
      unique case (code)
         mmsc_pkg::VTX_BR, mmsc_pkg::VTX_BL, mmsc_pkg::VTX_BM: off_y = CS_C;
         mmsc_pkg::VTX_LM, mmsc_pkg::VTX_RM:                   off_y = HALF_C;
         default:                                              off_y = '0;
      endcase
      if (case_ff == 4'd0) begin
         word_in = '{case_index: 4'd0, vertex_valid: 1'b0, vertex_x: '0,
                     vertex_y: '0, last_vertex: 1'b1};
      end else begin
         word_in = '{case_index: case_ff, vertex_valid: 1'b1,
                     vertex_x: x0_ff + off_x, vertex_y: y0_ff + off_y,
                     last_vertex: code_next == mmsc_pkg::VTX_END};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         case_ff      <= 4'd0;
         emit_idx_ff  <= 3'd0;
         for (int i = 0; i < 4; i++) sum_ff[i] <= '0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!out_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  for (int i = 0; i < 4; i++) begin
                     d2_ff[i]  <= q_data[mmsc_pkg::ENT_FIX + i*D2W +: D2W];
                     rem_ff[i] <= D2W'(q_rsq[mmsc_pkg::RSQ_W-1:8]);
                     sat_ff[i] <= D2W'(q_rsq[mmsc_pkg::RSQ_W-1:8]) >=
                                  q_data[mmsc_pkg::ENT_FIX + i*D2W +: D2W];
                     quo_ff[i] <= '0;
                  end
                  num_ff   <= {q_rsq[7:0], 16'd0};
                  x0_ff    <= q_data[2*CW+1 -: CW];
                  y0_ff    <= q_data[CW+1 -: CW];
                  first_ff <= q_data[1];
                  last_ff  <= q_data[0];
                  step_ff  <= 5'd0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               for (int i = 0; i < 4; i++) begin
                  rem_ff[i] <= rem_in[i];
                  quo_ff[i] <= quo_in[i];
               end
               num_ff  <= {num_ff[SW-2:0], 1'b0};
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(mmsc_pkg::DIV_STEPS - 1)) state_ff <= ST_ACC;
            end
            ST_ACC: begin
               for (int i = 0; i < 4; i++) sum_ff[i] <= sum_in[i];
               if (last_ff) begin
                  case_ff     <= case_in;
                  emit_idx_ff <= 3'd0;
                  state_ff    <= ST_EMIT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_ff       <= word_in;
                  emit_idx_ff  <= emit_idx_ff + 3'd1;
                  if (word_in.last_vertex) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_word  = rsp_ff;
   assign empty_ok  = rsp_ff.last_vertex && (rsp_ff.case_index == 4'd0);

   `MMSC_ASSERT_RST(a_reset_drops_output, clock, reset |=> !rsp_valid_ff)
   `MMSC_ASSERT(a_empty_last, clock, reset, rsp_valid_ff && !rsp_ff.vertex_valid |-> empty_ok)
   `MMSC_ASSERT(a_emit_in_range, clock, reset, state_ff == ST_EMIT |-> emit_idx_ff < 3'd6)

endmodule

// ----- rtl/core/metaball_marching_squares_cell_core.sv -----
// Top level of the metaball marching-squares cell core.
// Path from an accepted last-ball word to its first result: 2 front stages, queue write,
//   pop, 24 divider steps in the back end, accumulate, output register.
// The back end takes one ball at a time (pop, 24 divider steps, accumulate), set by the
//   bit-serial dividers; a last ball then emits its results (1 to 6), held by output stalls.
// Reset (synchronous, active high) clears all valids, the queue, the corner sums and
//   the case, and sets the threshold to 1.0; no clearing pass is needed.
module metaball_marching_squares_cell_core #(
   parameter int CELL_SIZE = 5
) (
   input  logic                clock,
   input  logic                reset,
   // configuration: iso threshold, Q8.16
   input  logic                csr_wr_en,
   input  logic [23:0]         csr_wr_data,
   // ball words in
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_cell_col,
   input  logic [6:0]          req_cell_row,
   input  logic signed [11:0]  req_ball_x,
   input  logic signed [11:0]  req_ball_y,
   input  logic [9:0]          req_ball_radius,
   input  logic                req_first_ball,
   input  logic                req_last_ball,
   // vertex words out
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_case_index,
   output logic                rsp_vertex_valid,
   output logic [9:0]          rsp_vertex_x,
   output logic [9:0]          rsp_vertex_y,
   output logic                rsp_last_vertex
);

   // corner coordinate width covers the far corner of the largest column
   localparam int CRD_W = $clog2(256 * CELL_SIZE + 1);
   // signed distance width: room for ball and corner coordinates plus sign
   localparam int DW    = ((CRD_W > 12) ? CRD_W : 12) + 2;
   // squared distance, summed over two axes, still fits 2*DW bits
   localparam int D2W   = 2 * DW;
   // queue word: four squared distances, radius squared, origin, flags
   localparam int EW    = 4 * D2W + mmsc_pkg::ENT_FIX;

   logic [mmsc_pkg::SUM_W-1:0] iso_ff;
   logic                       push_valid, q_full, q_valid, q_pop;
   logic [EW-1:0]              push_data, q_data;
   mmsc_pkg::rsp_word_type     word;

   // threshold register; writes only while the core is idle, a rule the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff <= mmsc_pkg::ISO_RESET;
      end else if (csr_wr_en) begin
         iso_ff <= csr_wr_data;
      end
   end

   // front end: register the word, square the corner offsets
   mmsc_front #(
      .CELL_SIZE(CELL_SIZE), .CRD_W(CRD_W), .DW(DW), .D2W(D2W), .EW(EW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .cell_col    (req_cell_col),
      .cell_row    (req_cell_row),
      .ball_x      (req_ball_x),
      .ball_y      (req_ball_y),
      .ball_radius (req_ball_radius),
      .first_ball  (req_first_ball),
      .last_ball   (req_last_ball),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_full   (q_full)
   );

   // decouple the front from the long division in the back
   mmsc_queue #(.EW(EW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   // back end: divide, accumulate, classify, emit the polygon
   mmsc_back #(.CELL_SIZE(CELL_SIZE), .D2W(D2W), .EW(EW)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .iso_threshold (iso_ff),
      .out_valid     (rsp_valid),
      .out_word      (word),
      .out_stall     (rsp_stall)
   );

   assign rsp_case_index   = word.case_index;
   assign rsp_vertex_valid = word.vertex_valid;
   assign rsp_vertex_x     = word.vertex_x;
   assign rsp_vertex_y     = word.vertex_y;
   assign rsp_last_vertex  = word.last_vertex;

endmodule
